### src/sbpg_pkg.sv
`timescale 1ns / 1ps

package sbpg_pkg;

    // Field widths.
    localparam int WordW  = 64;
    localparam int PairW  = 7;
    localparam int IdxW   = 8;
    localparam int HalfW  = 32;
    localparam int KeepN  = 5;

    // MT19937-64 constants.
    localparam logic [WordW-1:0] MtMult   = 64'd6364136223846793005;
    localparam logic [WordW-1:0] MtMatrix = 64'hB502_6F5A_A966_19E9;
    localparam logic [WordW-1:0] MtUpper  = 64'hFFFF_FFFF_8000_0000;
    localparam logic [WordW-1:0] MtLower  = 64'h0000_0000_7FFF_FFFF;

    // Seeding indexes of the words that the first two draws depend on.
    localparam logic [IdxW-1:0] IdxFirst = 8'd1;
    localparam logic [IdxW-1:0] IdxKeep1 = 8'd1;
    localparam logic [IdxW-1:0] IdxKeep2 = 8'd2;
    localparam logic [IdxW-1:0] IdxKeepM = 8'd156;
    localparam logic [IdxW-1:0] IdxLast  = 8'd157;

    // Slots of the kept word store.
    localparam logic [2:0] KwSeed  = 3'd0;
    localparam logic [2:0] KwOne   = 3'd1;
    localparam logic [2:0] KwTwo   = 3'd2;
    localparam logic [2:0] KwMid   = 3'd3;
    localparam logic [2:0] KwMidP1 = 3'd4;

    typedef enum logic [1:0] {
        CORE_IDLE,
        CORE_SEED,
        CORE_DRAW_A,
        CORE_DRAW_B
    } t_core_state;

    typedef enum logic [1:0] {
        MUL_LOW,
        MUL_CROSS_A,
        MUL_CROSS_B
    } t_mul_phase;

    typedef enum logic [1:0] {
        TOP_IDLE,
        TOP_WAIT,
        TOP_EMIT
    } t_top_state;

    // Request from the top level to the generator core.
    typedef struct packed {
        logic             start;
        logic [WordW-1:0] seed;
    } t_seed_req;

    // Result of the generator core: both tempered draws and a done strobe.
    typedef struct packed {
        logic             done;
        logic [WordW-1:0] draw_a;
        logic [WordW-1:0] draw_b;
    } t_draws;

    function automatic logic [WordW-1:0] temper(input logic [WordW-1:0] y_in);
        logic [WordW-1:0] y;
        y = y_in;
        y = y ^ ((y >> 29) & 64'h5555_5555_5555_5555);
        y = y ^ ((y << 17) & 64'h71D6_7FFF_EDA6_0000);
        y = y ^ ((y << 37) & 64'hFFF7_EEE0_0000_0000);
        y = y ^ (y >> 43);
        return y;
    endfunction

    function automatic logic [WordW-1:0] twist(input logic [WordW-1:0] cur,
                                               input logic [WordW-1:0] nxt,
                                               input logic [WordW-1:0] far);
        logic [WordW-1:0] x;
        logic [WordW-1:0] xa;
        x  = (cur & MtUpper) | (nxt & MtLower);
        xa = x >> 1;
        if (x[0]) begin
            xa = xa ^ MtMatrix;
        end
        return far ^ xa;
    endfunction

endpackage

### src/sbpg_if.sv
`timescale 1ns / 1ps

// Input channel: one seed and mode per transaction.
interface sbpg_in_if;
    logic        valid;
    logic        ready;
    logic [63:0] seed;
    logic        opcode;

    modport source (output valid, output seed, output opcode, input ready);
    modport sink   (input valid, input seed, input opcode, output ready);
endinterface

// Output channel: one word pair per transaction.
interface sbpg_out_if;
    logic        valid;
    logic        ready;
    logic [63:0] first_word;
    logic [63:0] second_word;
    logic        last;

    modport source (output valid, output first_word, output second_word, output last,
                    input ready);
    modport sink   (input valid, input first_word, input second_word, input last,
                    output ready);
endinterface

### src/sbpg_core.sv
`timescale 1ns / 1ps

module sbpg_core import sbpg_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_seed_req i_req,
    output t_draws    o_draws
);

    t_core_state r_state, n_state;
    t_mul_phase  r_phase, n_phase;
    logic [IdxW-1:0]  r_idx;
    logic [WordW-1:0] r_chain;
    logic [WordW-1:0] r_p0;
    logic [HalfW-1:0] r_cross;
    logic [WordW-1:0] r_kw [KeepN];
    logic [WordW-1:0] r_a;
    logic [WordW-1:0] r_b;
    logic             r_done;

    logic [WordW-1:0] w_x;
    logic [HalfW-1:0] w_mul_a;
    logic [HalfW-1:0] w_mul_b;
    logic [WordW-1:0] w_prod;
    logic [HalfW:0]   w_lo;
    logic [HalfW-1:0] w_hi;
    logic [WordW-1:0] w_chain_next;
    logic [WordW-1:0] w_cur, w_nxt, w_far;
    logic [WordW-1:0] w_draw;
    logic             w_seed_step;
    logic             w_step_end;
    logic             w_take_a;
    logic             w_take_b;

    // Recurrence input: chain ^ (chain >> 62).
    assign w_x = r_chain ^ (r_chain >> 62);

    // Shared 32x32 multiplier; its operands rotate over the three phases of a step.
    always_comb begin
        unique case (r_phase)
            MUL_LOW: begin
                w_mul_a = w_x[HalfW-1:0];
                w_mul_b = MtMult[HalfW-1:0];
            end
            MUL_CROSS_A: begin
                w_mul_a = w_x[HalfW-1:0];
                w_mul_b = MtMult[WordW-1:HalfW];
            end
            MUL_CROSS_B: begin
                w_mul_a = w_x[WordW-1:HalfW];
                w_mul_b = MtMult[HalfW-1:0];
            end
            default: begin
                w_mul_a = w_x[HalfW-1:0];
                w_mul_b = MtMult[HalfW-1:0];
            end
        endcase
    end

    assign w_prod = {{HalfW{1'b0}}, w_mul_a} * {{HalfW{1'b0}}, w_mul_b};

    // Final assembly of the step: low product, both cross terms in the upper half, plus index.
    assign w_lo = {1'b0, r_p0[HalfW-1:0]} + {{(HalfW + 1 - IdxW){1'b0}}, r_idx};
    assign w_hi = r_p0[WordW-1:HalfW] + r_cross + w_prod[HalfW-1:0]
                  + {{(HalfW - 1){1'b0}}, w_lo[HalfW]};
    assign w_chain_next = {w_hi, w_lo[HalfW-1:0]};

    // Shared twist and temper unit, used once for each draw.
    always_comb begin
        if (r_state == CORE_DRAW_B) begin
            w_cur = r_kw[KwOne];
            w_nxt = r_kw[KwTwo];
            w_far = r_kw[KwMidP1];
        end else begin
            w_cur = r_kw[KwSeed];
            w_nxt = r_kw[KwOne];
            w_far = r_kw[KwMid];
        end
    end

    assign w_draw = temper(twist(w_cur, w_nxt, w_far));

    // Next state of the sequencer.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            CORE_IDLE: begin
                if (i_req.start) begin
                    n_state = CORE_SEED;
                end
            end
            CORE_SEED: begin
                if (r_phase == MUL_CROSS_B && r_idx == IdxLast) begin
                    n_state = CORE_DRAW_A;
                end
            end
            CORE_DRAW_A: begin
                n_state = CORE_DRAW_B;
            end
            CORE_DRAW_B: begin
                n_state = CORE_IDLE;
            end
            default: begin
                n_state = CORE_IDLE;
            end
        endcase
    end

    // Sequencer outputs.
    always_comb begin
        w_seed_step = 1'b0;
        w_take_a    = 1'b0;
        w_take_b    = 1'b0;
        unique case (r_state)
            CORE_IDLE:   w_seed_step = 1'b0;
            CORE_SEED:   w_seed_step = 1'b1;
            CORE_DRAW_A: w_take_a    = 1'b1;
            CORE_DRAW_B: w_take_b    = 1'b1;
            default:     w_seed_step = 1'b0;
        endcase
    end

    assign w_step_end = w_seed_step && (r_phase == MUL_CROSS_B);

    // Phase rotation within a seeding step.
    always_comb begin
        n_phase = r_phase;
        if (w_seed_step) begin
            unique case (r_phase)
                MUL_LOW:     n_phase = MUL_CROSS_A;
                MUL_CROSS_A: n_phase = MUL_CROSS_B;
                MUL_CROSS_B: n_phase = MUL_LOW;
                default:     n_phase = MUL_LOW;
            endcase
        end else begin
            n_phase = MUL_LOW;
        end
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= CORE_IDLE;
            r_phase <= MUL_LOW;
            r_idx   <= IdxFirst;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_phase <= n_phase;
            r_done  <= w_take_b;
            if (r_state == CORE_IDLE && i_req.start) begin
                r_idx <= IdxFirst;
            end else if (w_step_end) begin
                r_idx <= r_idx + 8'd1;
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        if (r_state == CORE_IDLE && i_req.start) begin
            r_chain      <= i_req.seed;
            r_kw[KwSeed] <= i_req.seed;
        end
        if (w_seed_step && r_phase == MUL_LOW) begin
            r_p0 <= w_prod;
        end
        if (w_seed_step && r_phase == MUL_CROSS_A) begin
            r_cross <= w_prod[HalfW-1:0];
        end
        if (w_step_end) begin
            r_chain <= w_chain_next;
            if (r_idx == IdxKeep1) begin
                r_kw[KwOne] <= w_chain_next;
            end
            if (r_idx == IdxKeep2) begin
                r_kw[KwTwo] <= w_chain_next;
            end
            if (r_idx == IdxKeepM) begin
                r_kw[KwMid] <= w_chain_next;
            end
            if (r_idx == IdxLast) begin
                r_kw[KwMidP1] <= w_chain_next;
            end
        end
        if (w_take_a) begin
            r_a <= w_draw;
        end
        if (w_take_b) begin
            r_b <= w_draw;
        end
    end

    assign o_draws = '{done: r_done, draw_a: r_a, draw_b: r_b};

endmodule

### src/seeded_block_pattern_generator_unit.sv
`timescale 1ns / 1ps
// Channel    | Dir | Handshake    | Payload
// i_in_ch    | in  | valid/ready  | seed[63:0], opcode
// o_out_ch   | out | valid/ready  | first_word[63:0], second_word[63:0], last
// i_cfg_*    | in  | write enable | i_cfg_wdata[6:0] = block_pairs
//
// A block runs 157 seeding steps, each a low product and two cross products on the one
// shared 32x32 multiplier, then a twist and temper for each of the two draws, which are
// registered before the first pair; then one pair per cycle while the output is not stalled.
// Input ready is high only between blocks; the last pair may still wait in the
// output register while the next block is seeded.
// Synchronous active-low reset; block_pairs resets to 64.

module seeded_block_pattern_generator_unit import sbpg_pkg::*; #(
    parameter int MAX_PAIRS = 64
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    sbpg_in_if.sink           i_in_ch,
    sbpg_out_if.source        o_out_ch,
    input  logic              i_cfg_we,
    input  logic [PairW-1:0]  i_cfg_wdata
);

    localparam logic [PairW-1:0] MaxPairs = PairW'(MAX_PAIRS);
    localparam logic [PairW-1:0] ResetPairs = 7'd64;

    t_top_state r_state, n_state;
    logic [PairW-1:0] r_block_pairs;
    logic [PairW-1:0] r_len;
    logic [PairW-1:0] r_pidx;
    logic             r_wrong;
    logic             r_zero_block;
    logic [WordW-1:0] r_first;
    logic [WordW-1:0] r_second;
    logic             r_out_valid;
    logic [WordW-1:0] r_out_first;
    logic [WordW-1:0] r_out_second;
    logic             r_out_last;

    t_seed_req        w_req;
    t_draws           w_draws;
    logic             w_in_ready;
    logic             w_accept;
    logic             w_load;
    logic             w_final;
    logic [PairW-1:0] w_len_sat;

    assign w_len_sat = (r_block_pairs > MaxPairs) ? MaxPairs : r_block_pairs;
    assign w_accept  = i_in_ch.valid && w_in_ready;
    assign w_load    = (r_state == TOP_EMIT) && (!r_out_valid || o_out_ch.ready);
    assign w_final   = (r_pidx + 7'd1) == r_len;

    sbpg_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .o_draws (w_draws)
    );

    // Next state of the block sequencer.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            TOP_IDLE: begin
                if (w_accept) begin
                    n_state = TOP_WAIT;
                end
            end
            TOP_WAIT: begin
                if (w_draws.done) begin
                    n_state = (r_len == '0) ? TOP_IDLE : TOP_EMIT;
                end
            end
            TOP_EMIT: begin
                if (w_load && w_final) begin
                    n_state = TOP_IDLE;
                end
            end
            default: begin
                n_state = TOP_IDLE;
            end
        endcase
    end

    // Sequencer outputs.
    always_comb begin
        w_in_ready = 1'b0;
        unique case (r_state)
            TOP_IDLE: w_in_ready = 1'b1;
            TOP_WAIT: w_in_ready = 1'b0;
            TOP_EMIT: w_in_ready = 1'b0;
            default:  w_in_ready = 1'b0;
        endcase
    end

    assign w_req = '{start: w_accept, seed: i_in_ch.seed};

    // Control registers, configuration included.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= TOP_IDLE;
            r_block_pairs <= ResetPairs;
            r_out_valid   <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_block_pairs <= i_cfg_wdata;
            end
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (o_out_ch.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Block parameters latched at the input transaction.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_len        <= w_len_sat;
            r_wrong      <= i_in_ch.opcode;
            r_zero_block <= !i_in_ch.opcode && (i_in_ch.seed == '0);
        end
    end

    // Running words: the draws (adjusted for the wrong opcode) first, then one step per emitted pair.
    always_ff @(posedge i_clk) begin
        if (r_state == TOP_WAIT && w_draws.done) begin
            r_pidx <= '0;
            if (r_wrong) begin
                r_first  <= w_draws.draw_a - 64'd1;
                r_second <= w_draws.draw_b + 64'd1;
            end else begin
                r_first  <= w_draws.draw_a;
                r_second <= w_draws.draw_b;
            end
        end else if (w_load) begin
            r_pidx   <= r_pidx + 7'd1;
            r_first  <= r_first + 64'd1;
            r_second <= r_second - 64'd1;
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_out_first  <= r_zero_block ? '0 : r_first;
            r_out_second <= r_zero_block ? '0 : r_second;
            r_out_last   <= w_final;
        end
    end

    assign i_in_ch.ready        = w_in_ready;
    assign o_out_ch.valid       = r_out_valid;
    assign o_out_ch.first_word  = r_out_first;
    assign o_out_ch.second_word = r_out_second;
    assign o_out_ch.last        = r_out_last;

endmodule

### src/sbpg_checker.sv
`timescale 1ns / 1ps

module sbpg_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        i_in_ready,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [63:0] i_out_first,
    input logic [63:0] i_out_second,
    input logic        i_out_last,
    input logic        i_cfg_we,
    input logic [6:0]  i_cfg_wdata
);

    logic       r_len_nz;
    logic [1:0] r_pending;
    logic       w_accept;
    logic       w_block_done;

    assign w_accept     = i_in_valid && i_in_ready;
    assign w_block_done = i_out_valid && i_out_ready && i_out_last;

    // Blocks accepted with a nonzero length whose last pair is not yet taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len_nz  <= 1'b1;
            r_pending <= 2'd0;
        end else begin
            if (i_cfg_we) begin
                r_len_nz <= (i_cfg_wdata != 7'd0);
            end
            r_pending <= r_pending + {1'b0, w_accept && r_len_nz}
                         - {1'b0, w_block_done};
        end
    end

    // A block is worked on alone: ready drops right after a transaction is taken.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> !i_in_ready)
        else $error("input ready high right after an input transaction");

    // A stalled output transaction keeps its payload.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=>
            (i_out_valid && $stable(i_out_first) && $stable(i_out_second)
             && $stable(i_out_last)))
        else $error("stalled output transaction changed");

    // No pair appears without a block in flight.
    a_no_orphan_pair: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (r_pending != 2'd0))
        else $error("output pair without an open block");

    // At most the previous block's last pair may still wait when a new block starts.
    a_overlap_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |-> (r_pending == 2'd0 || r_pending == 2'd1))
        else $error("new block accepted with more than one block open");

endmodule

bind seeded_block_pattern_generator_unit sbpg_checker u_sbpg_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_in_ch.valid),
    .i_in_ready   (i_in_ch.ready),
    .i_out_valid  (o_out_ch.valid),
    .i_out_ready  (o_out_ch.ready),
    .i_out_first  (o_out_ch.first_word),
    .i_out_second (o_out_ch.second_word),
    .i_out_last   (o_out_ch.last),
    .i_cfg_we     (i_cfg_we),
    .i_cfg_wdata  (i_cfg_wdata)
);

### dv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import sbpg_pkg::*;

    // Generator constants, kept local so the prediction stands on its own.
    localparam int unsigned MaxPairs      = 64;
    localparam int unsigned SeedSteps     = 157;
    localparam int unsigned KeepMid       = 156;
    localparam logic [63:0] SeedMult      = 64'd6364136223846793005;
    localparam logic [63:0] TwistMatrix   = 64'hB502_6F5A_A966_19E9;
    localparam logic [63:0] TwistUpper    = 64'hFFFF_FFFF_8000_0000;
    localparam logic [63:0] TwistLower    = 64'h0000_0000_7FFF_FFFF;
    localparam logic        OpNormal      = 1'b0;
    localparam logic        OpWrong       = 1'b1;
    localparam int unsigned MaxWait       = 6;
    localparam int unsigned SettleCycles  = 600;
    localparam int unsigned WatchdogLimit = 4000;
    localparam int unsigned ReportLimit   = 10;
    localparam int unsigned RandomPhases  = 10;
    localparam int unsigned PhaseItems    = 25;

    typedef struct packed {
        logic [63:0] seed;
        logic        op;
    } t_tb_req;

    typedef struct packed {
        logic [63:0] first_word;
        logic [63:0] second_word;
        logic        last;
    } t_tb_pair;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    // Testbench-side drivers of the block inputs, all known from time zero.
    logic              in_valid  = 1'b0;
    logic [63:0]       in_seed   = '0;
    logic              in_op     = OpNormal;
    logic              out_ready = 1'b0;
    logic              cfg_we    = 1'b0;
    logic [PairW-1:0]  cfg_wdata = '0;
    logic              steady_flow = 1'b0;

    sbpg_in_if  in_ch ();
    sbpg_out_if out_ch ();

    assign in_ch.valid  = in_valid;
    assign in_ch.seed   = in_seed;
    assign in_ch.opcode = in_op;
    assign out_ch.ready = out_ready;

    seeded_block_pattern_generator_unit #(
        .MAX_PAIRS(MaxPairs)
    ) i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_ch    (in_ch),
        .o_out_ch   (out_ch),
        .i_cfg_we   (cfg_we),
        .i_cfg_wdata(cfg_wdata)
    );

    t_tb_req     pending_seeds[$];
    t_tb_pair    expected_pairs[$];
    logic [PairW-1:0] pairs_setting = 7'd64;
    int unsigned fault_count = 0;
    int unsigned gap_left    = 0;
    int unsigned stall_left  = 0;
    int unsigned quiet_cycles = 0;

    // Clock: 2 ns period.
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Output scrambling of one generator word.
    function automatic logic [63:0] temper_word(input logic [63:0] w);
        logic [63:0] y;
        y = w;
        y = y ^ ((y >> 29) & 64'h5555_5555_5555_5555);
        y = y ^ ((y << 17) & 64'h71D6_7FFF_EDA6_0000);
        y = y ^ ((y << 37) & 64'hFFF7_EEE0_0000_0000);
        y = y ^ (y >> 43);
        return y;
    endfunction

    // One state regeneration step for a single word.
    function automatic logic [63:0] twist_word(input logic [63:0] cur,
                                              input logic [63:0] nxt_w,
                                              input logic [63:0] far_w);
        logic [63:0] x;
        logic [63:0] xa;
        x  = (cur & TwistUpper) | (nxt_w & TwistLower);
        xa = x >> 1;
        if (x[0]) begin
            xa = xa ^ TwistMatrix;
        end
        return far_w ^ xa;
    endfunction

    // Computes the pattern block for one seed and queues its word pairs.
    function automatic void queue_block_pairs(input logic [63:0] seed, input logic op);
        logic [63:0] chain;
        logic [63:0] w0, w1, w2, wm, wm1;
        logic [63:0] draw_a, draw_b;
        t_tb_pair    pair;
        int unsigned len;
        bit          zero_block;
        chain = seed;
        w0 = seed;
        w1 = '0;
        w2 = '0;
        wm = '0;
        wm1 = '0;
        for (int unsigned i = 1; i <= SeedSteps; i++) begin
            chain = SeedMult * (chain ^ (chain >> 62)) + 64'(i);
            if (i == 1) w1 = chain;
            if (i == 2) w2 = chain;
            if (i == KeepMid) wm = chain;
            if (i == SeedSteps) wm1 = chain;
        end
        draw_a = temper_word(twist_word(w0, w1, wm));
        draw_b = temper_word(twist_word(w1, w2, wm1));
        zero_block = (op == OpNormal) && (seed == '0);
        if (op == OpWrong) begin
            draw_a = draw_a - 64'd1;
            draw_b = draw_b + 64'd1;
        end
        len = (pairs_setting > MaxPairs) ? MaxPairs : pairs_setting;
        for (int unsigned k = 0; k < len; k++) begin
            pair.first_word  = zero_block ? '0 : draw_a + 64'(k);
            pair.second_word = zero_block ? '0 : draw_b - 64'(k);
            pair.last        = (k + 1 == len);
            expected_pairs = {expected_pairs, pair};
        end
    endfunction

    function automatic int unsigned draw_wait();
        return steady_flow ? 0 : $urandom_range(0, MaxWait);
    endfunction

    // Seed driver: presents queued seeds and predicts each accepted transaction.
    always @(posedge i_clk) begin : seed_driver
        t_tb_req nxt;
        if (!i_rst_n) begin
            in_valid <= 1'b0;
            gap_left <= 0;
        end else begin
            if (in_valid && in_ch.ready) begin
                queue_block_pairs(in_seed, in_op);
            end
            if (!in_valid || in_ch.ready) begin
                if (gap_left != 0) begin
                    gap_left <= gap_left - 1;
                    in_valid <= 1'b0;
                end else if (pending_seeds.size() != 0) begin
                    nxt = pending_seeds.pop_front();
                    in_valid <= 1'b1;
                    in_seed  <= nxt.seed;
                    in_op    <= nxt.op;
                    gap_left <= draw_wait();
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Pair monitor: applies back-pressure and checks each accepted transaction.
    always @(posedge i_clk) begin : pair_monitor
        t_tb_pair want;
        int unsigned hold;
        if (!i_rst_n) begin
            out_ready  <= 1'b0;
            stall_left <= 0;
        end else if (out_ready && out_ch.valid) begin
            if (expected_pairs.size() == 0) begin
                fault_count++;
                if (fault_count <= ReportLimit) begin
                    $display("%0t: unexpected pair first=%h second=%h last=%b", $realtime,
                             out_ch.first_word, out_ch.second_word, out_ch.last);
                end
            end else begin
                want = expected_pairs.pop_front();
                if (out_ch.first_word !== want.first_word ||
                    out_ch.second_word !== want.second_word ||
                    out_ch.last !== want.last) begin
                    fault_count++;
                    if (fault_count <= ReportLimit) begin
                        $display("%0t: first exp %h got %h, second exp %h got %h,",
                                 $realtime, want.first_word, out_ch.first_word,
                                 want.second_word, out_ch.second_word);
                        $display("    last exp %b got %b", want.last, out_ch.last);
                    end
                end
            end
            hold = draw_wait();
            if (hold != 0) begin
                out_ready  <= 1'b0;
                stall_left <= hold - 1;
            end
        end else if (!out_ready) begin
            if (stall_left == 0) begin
                out_ready <= 1'b1;
            end else begin
                stall_left <= stall_left - 1;
            end
        end
    end

    // Watchdog on cycles in which no transaction moves on either channel.
    always @(posedge i_clk) begin
        if (!i_rst_n || (in_valid && in_ch.ready) || (out_ready && out_ch.valid)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WatchdogLimit) begin
            $display("seeded_block_pattern_generator_unit: mismatch");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic push_seed(input logic [63:0] seed, input logic op);
        t_tb_req req;
        req.seed = seed;
        req.op   = op;
        pending_seeds = {pending_seeds, req};
    endtask

    // Waits until every queued seed is taken and every pair has arrived,
    // then lets a zero-length block finish its seeding.
    task automatic drain_and_settle();
        while (pending_seeds.size() != 0 || in_valid || expected_pairs.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (SettleCycles) @(negedge i_clk);
    endtask

    task automatic set_pairs(input logic [PairW-1:0] value);
        @(posedge i_clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge i_clk);
        cfg_we <= 1'b0;
        pairs_setting = value;
        @(negedge i_clk);
    endtask

    function automatic logic [63:0] random_seed();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return '1;
            2: return 64'($urandom_range(0, 15));
            default: return {$urandom, $urandom};
        endcase
    endfunction

    function automatic logic [PairW-1:0] random_pairs();
        case ($urandom_range(0, 9))
            6: return 7'd0;
            7: return 7'd64;
            8: return 7'd127;
            9: return PairW'($urandom_range(1, 127));
            default: return PairW'($urandom_range(1, 8));
        endcase
    endfunction

    // Stimulus: directed seeds over the length extremes, then random phases.
    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Reset length: zero seed in both modes and bit-pattern extremes.
        push_seed(64'd0, OpNormal);
        push_seed(64'd0, OpWrong);
        push_seed('1, OpNormal);
        push_seed('1, OpWrong);
        push_seed(64'd1, OpNormal);
        push_seed(64'h8000_0000_0000_0000, OpWrong);
        push_seed(64'h5555_5555_5555_5555, OpNormal);
        push_seed(64'hAAAA_AAAA_AAAA_AAAA, OpWrong);
        drain_and_settle();

        // Single-pair blocks.
        steady_flow = 1'b1;
        set_pairs(7'd1);
        push_seed(64'd0, OpNormal);
        push_seed('1, OpWrong);
        push_seed(64'h0123_4567_89AB_CDEF, OpNormal);
        drain_and_settle();

        // Empty blocks produce nothing.
        set_pairs(7'd0);
        push_seed('1, OpNormal);
        push_seed(64'd0, OpWrong);
        drain_and_settle();

        // Lengths above the maximum saturate; then a block at the maximum.
        steady_flow = 1'b0;
        set_pairs(7'd127);
        push_seed(64'd0, OpNormal);
        push_seed(64'hFEDC_BA98_7654_3210, OpWrong);
        drain_and_settle();

        set_pairs(7'd65);
        push_seed(64'd2, OpNormal);
        drain_and_settle();

        set_pairs(7'd64);
        push_seed(64'h0F0F_F0F0_3C3C_C3C3, OpWrong);
        drain_and_settle();

        // Random phases, each with its own length and flow style.
        for (int unsigned p = 0; p < RandomPhases; p++) begin
            steady_flow = ($urandom_range(0, 3) == 0);
            set_pairs(random_pairs());
            for (int unsigned n = 0; n < PhaseItems; n++) begin
                push_seed(random_seed(), $urandom_range(0, 1) ? OpWrong : OpNormal);
            end
            drain_and_settle();
        end

        if (fault_count == 0 && expected_pairs.size() == 0) begin
            $display("seeded_block_pattern_generator_unit: match");
        end else begin
            $display("seeded_block_pattern_generator_unit: mismatch");
        end
        $finish;
    end

endmodule

### sim.f
src/sbpg_pkg.sv
src/sbpg_if.sv
src/sbpg_core.sv
src/seeded_block_pattern_generator_unit.sv
src/sbpg_checker.sv
dv/tb_top.sv
